// ===== rtl/ksm_pkg.sv =====
// Shared constants, types and helpers for the key sequence matcher.
`default_nettype none
package ksm_pkg;

  localparam int KEY_COUNT_DEF     = 6;
  localparam int MAX_KEY_BYTES_DEF = 8;

  localparam int KEY_W      = 64;
  localparam int KEY_BYTES  = 8;
  localparam int LEN_W      = 4;
  localparam int TIMEOUT_W  = 8;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_KEY_REGS = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGEST = 3'd7;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd2;
  localparam logic [LEN_W-1:0]     LONGEST_RST = 4'd8;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = 8'hFF;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } ksm_cmd_t;

  function automatic logic [LEN_W-1:0] key_length(input logic [KEY_W-1:0] key);
    logic [LEN_W-1:0] n;
    logic             done;
    n    = '0;
    done = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!done && key[8*i +: 8] != 8'd0) begin
        n = n + LEN_W'(1);
      end else begin
        done = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ksm_cfg.sv =====
// Configuration registers: key strings with their lengths, timeout and length limit.
`default_nettype none
module ksm_cfg
  import ksm_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [KEY_W-1:0]      cfg_data_i,
  output logic [KEY_COUNT-1:0][KEY_W-1:0] key_o,
  output logic [KEY_COUNT-1:0][LEN_W-1:0] key_len_o,
  output logic [TIMEOUT_W-1:0]       timeout_o,
  output logic [LEN_W-1:0]           longest_o
);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [LEN_W-1:0]     longest_q;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    if (k < NUM_KEY_REGS) begin : g_reg
      logic [KEY_W-1:0] key_q;
      logic [LEN_W-1:0] len_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          key_q <= '0;
          len_q <= '0;
        end else if (cfg_we_i && cfg_index_i == CFG_IDX_W'(k)) begin
          key_q <= cfg_data_i;
          len_q <= key_length(cfg_data_i);
        end
      end
      assign key_o[k]     = key_q;
      assign key_len_o[k] = len_q;
    end else begin : g_none
      assign key_o[k]     = '0;
      assign key_len_o[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      longest_q <= LONGEST_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
      end
      if (cfg_index_i == CFG_LONGEST) begin
        longest_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  assign timeout_o = timeout_q;
  assign longest_o = longest_q;

endmodule
`default_nettype wire

// ===== rtl/ksm_step.sv =====
// Next-state and command logic for one word: flush, append and prefix match.
`default_nettype none
module ksm_step
  import ksm_pkg::*;
#(
  parameter int KEY_COUNT     = KEY_COUNT_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int FILL_W       = $clog2(MAX_KEY_BYTES + 1)
) (
  input  wire logic                               opcode_i,
  input  wire logic [7:0]                         key_byte_i,
  input  wire logic [MAX_KEY_BYTES-1:0][7:0]      store_i,
  input  wire logic [FILL_W-1:0]                  fill_i,
  input  wire logic [TIMEOUT_W-1:0]               idle_i,
  input  wire logic [KEY_COUNT-1:0][KEY_W-1:0]    key_i,
  input  wire logic [KEY_COUNT-1:0][LEN_W-1:0]    key_len_i,
  input  wire logic [TIMEOUT_W-1:0]               timeout_i,
  input  wire logic [LEN_W-1:0]                   longest_i,
  output logic                                    append_o,
  output logic [FILL_W-1:0]                       fill_o,
  output logic [TIMEOUT_W-1:0]                    idle_o,
  output ksm_cmd_t                                cmd_o
);

  logic [LEN_W-1:0]     lim;
  logic [LEN_W-1:0]     fill_old;
  logic [LEN_W-1:0]     fill_new;
  logic [TIMEOUT_W-1:0] idle_inc;
  logic                 flush;
  logic [KEY_COUNT-1:0] exact_old;
  logic [KEY_COUNT-1:0] exact_new;
  logic [KEY_COUNT-1:0] prefix_new;
  logic [MAX_KEY_BYTES-1:0][7:0] buf_new;
  ksm_cmd_t             cmd_old;
  ksm_cmd_t             cmd_new;

  assign fill_old = LEN_W'(fill_i);
  assign fill_new = fill_old + LEN_W'(1);

  always_comb begin
    if (longest_i == '0) begin
      lim = LEN_W'(1);
    end else if (longest_i > LEN_W'(MAX_KEY_BYTES)) begin
      lim = LEN_W'(MAX_KEY_BYTES);
    end else begin
      lim = longest_i;
    end
  end

  assign idle_inc = (!opcode_i && idle_i != IDLE_MAX) ? idle_i + TIMEOUT_W'(1) : idle_i;
  assign flush    = (idle_inc > timeout_i) || (fill_old >= lim);

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      buf_new[i] = (fill_old == LEN_W'(i)) ? key_byte_i : store_i[i];
    end
  end

  always_comb begin
    logic ok_old;
    logic ok_new;
    for (int k = 0; k < KEY_COUNT; k++) begin
      ok_old = 1'b1;
      ok_new = 1'b1;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if (fill_old > LEN_W'(i) && key_i[k][8*i +: 8] != store_i[i]) begin
          ok_old = 1'b0;
        end
        if (fill_new > LEN_W'(i) && key_i[k][8*i +: 8] != buf_new[i]) begin
          ok_new = 1'b0;
        end
      end
      exact_old[k]  = ok_old && key_len_i[k] != '0 && key_len_i[k] == fill_old;
      exact_new[k]  = ok_new && key_len_i[k] != '0 && key_len_i[k] == fill_new;
      prefix_new[k] = ok_new && key_len_i[k] != '0 && key_len_i[k] >= fill_new;
    end
  end

  always_comb begin
    cmd_old = '0;
    cmd_new = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (exact_old[k]) begin
        cmd_old.valid = 1'b1;
        cmd_old.index = IDX_W'(k);
      end
      if (exact_new[k]) begin
        cmd_new.valid = 1'b1;
        cmd_new.index = IDX_W'(k);
      end
    end
  end

  always_comb begin
    append_o = 1'b0;
    fill_o   = fill_i;
    idle_o   = idle_inc;
    cmd_o    = '0;
    if (flush) begin
      fill_o = '0;
      idle_o = '0;
      cmd_o  = cmd_old;
    end else if (opcode_i && key_byte_i != 8'd0) begin
      append_o = 1'b1;
      idle_o   = '0;
      if (prefix_new == '0) begin
        fill_o = '0;
      end else if (((prefix_new & (prefix_new - KEY_COUNT'(1))) == '0) && cmd_new.valid) begin
        fill_o = '0;
        cmd_o  = cmd_new;
      end else begin
        fill_o = FILL_W'(fill_new);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/key_sequence_matcher.sv =====
// Top level: input register, match state, result register and config port.
//
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_stall_o    opcode_i, key_byte_i
//  out      out  out_valid_o/out_stall_i  command_valid_o, command_index_o
//  cfg      in   cfg_we_i                 cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the result is not stalled; an accepted word
// reaches the result register through the input register and the compare logic.
// Reset clears the buffer fill count, idle count and both pipeline valids; keys reset empty.
// Out stall holds the result register; the input register fills, then in_stall_o rises.
`default_nettype none
module key_sequence_matcher
  import ksm_pkg::*;
#(
  parameter int KEY_COUNT     = KEY_COUNT_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 opcode_i,
  input  wire logic [7:0]           key_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      command_valid_o,
  output logic [IDX_W-1:0]          command_index_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [KEY_W-1:0]     cfg_data_i
);

  localparam int FILL_W = $clog2(MAX_KEY_BYTES + 1);
  localparam int ADDR_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [KEY_COUNT-1:0][KEY_W-1:0] key;
  logic [KEY_COUNT-1:0][LEN_W-1:0] key_len;
  logic [TIMEOUT_W-1:0]            timeout;
  logic [LEN_W-1:0]                longest;

  logic                          in_valid_q;
  logic                          opcode_q;
  logic [7:0]                    key_byte_q;
  logic [MAX_KEY_BYTES-1:0][7:0] store_q;
  logic [FILL_W-1:0]             fill_q;
  logic [FILL_W-1:0]             fill_d;
  logic [TIMEOUT_W-1:0]          idle_q;
  logic [TIMEOUT_W-1:0]          idle_d;
  logic                          out_valid_q;
  ksm_cmd_t                      cmd_q;
  ksm_cmd_t                      cmd_d;
  logic                          append;
  logic                          out_ready;
  logic                          advance;
  logic                          in_accept;

  ksm_cfg #(
    .KEY_COUNT (KEY_COUNT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key),
    .key_len_o   (key_len),
    .timeout_o   (timeout),
    .longest_o   (longest)
  );

  ksm_step #(
    .KEY_COUNT     (KEY_COUNT),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_step (
    .opcode_i   (opcode_q),
    .key_byte_i (key_byte_q),
    .store_i    (store_q),
    .fill_i     (fill_q),
    .idle_i     (idle_q),
    .key_i      (key),
    .key_len_i  (key_len),
    .timeout_i  (timeout),
    .longest_i  (longest),
    .append_o   (append),
    .fill_o     (fill_d),
    .idle_o     (idle_d),
    .cmd_o      (cmd_d)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      idle_q      <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        fill_q <= fill_d;
        idle_q <= idle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q   <= opcode_i;
      key_byte_q <= key_byte_i;
    end
    if (advance) begin
      cmd_q <= cmd_d;
      if (append) begin
        store_q[fill_q[ADDR_W-1:0]] <= key_byte_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_valid_o = cmd_q.valid;
  assign command_index_o = cmd_q.index;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_KEY_BYTES))
    else $error("buffer fill exceeds its depth");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed word did not reach the result register");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !command_valid_o) |-> (command_index_o == '0))
    else $error("index nonzero without a command");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_valid_o) |->
      ((IDX_W+1)'(command_index_o) < (IDX_W+1)'(KEY_COUNT)))
    else $error("command index out of key range");

endmodule
`default_nettype wire
